// ===== sv/pixel_format_to_rgb_rgba_macros.svh =====
// Assertion macros shared by the pixel format converter checkers
`ifndef PIXEL_FORMAT_TO_RGB_RGBA_MACROS_SVH
`define PIXEL_FORMAT_TO_RGB_RGBA_MACROS_SVH

// Clocked assertion, disabled while reset is held
`define PFRGB_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset
`define PFRGB_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/pfrgb_pkg.sv =====
// Shared types and channel widening functions for the pixel format converter
package pfrgb_pkg;

    typedef enum logic [2:0] {
        FMT_RGB888   = 3'd0,
        FMT_RGBA8888 = 3'd1,
        FMT_ARGB8888 = 3'd2,
        FMT_RGB565   = 3'd3,
        FMT_RGBA4444 = 3'd4,
        FMT_RGBA5551 = 3'd5
    } t_src_fmt;

    typedef enum logic [0:0] {
        CFG_SRC_FORMAT     = 1'b0,
        CFG_DST_WITH_ALPHA = 1'b1
    } t_cfg_index;

    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_rgba;

    // v*255/31 = 8v + floor(7v/31)
    function automatic logic [7:0] widen5(input logic [4:0] v);
        logic [2:0] corr;
        corr = 3'(v >= 5'd5)  + 3'(v >= 5'd9)  + 3'(v >= 5'd14) + 3'(v >= 5'd18)
             + 3'(v >= 5'd23) + 3'(v >= 5'd27) + 3'(v >= 5'd31);
        return {v, 3'b000} + {5'd0, corr};
    endfunction

    // v*255/63 = 4v + floor(v/21)
    function automatic logic [7:0] widen6(input logic [5:0] v);
        logic [1:0] corr;
        corr = 2'(v >= 6'd21) + 2'(v >= 6'd42) + 2'(v >= 6'd63);
        return {v, 2'b00} + {6'd0, corr};
    endfunction

    // v*255/15 = 17v
    function automatic logic [7:0] widen4(input logic [3:0] v);
        return {v, v};
    endfunction

    function automatic logic [7:0] widen1(input logic v);
        return {8{v}};
    endfunction

endpackage

// ===== sv/pfrgb_unpack.sv =====
// Source format decode and channel widening to 8 bits
module pfrgb_unpack (
    input  logic [31:0]         i_src_pixel,
    input  pfrgb_pkg::t_src_fmt i_src_format,
    output pfrgb_pkg::t_rgba    o_pix,
    output logic                o_fmt_ok
);
    import pfrgb_pkg::*;

    always_comb begin
        o_pix    = '0;
        o_fmt_ok = 1'b1;
        case (i_src_format)
            FMT_RGB888: begin
                o_pix.red   = i_src_pixel[23:16];
                o_pix.green = i_src_pixel[15:8];
                o_pix.blue  = i_src_pixel[7:0];
                o_pix.alpha = CHAN_MAX;
            end
            FMT_RGBA8888: begin
                o_pix.red   = i_src_pixel[31:24];
                o_pix.green = i_src_pixel[23:16];
                o_pix.blue  = i_src_pixel[15:8];
                o_pix.alpha = i_src_pixel[7:0];
            end
            FMT_ARGB8888: begin
                o_pix.alpha = i_src_pixel[31:24];
                o_pix.red   = i_src_pixel[23:16];
                o_pix.green = i_src_pixel[15:8];
                o_pix.blue  = i_src_pixel[7:0];
            end
            FMT_RGB565: begin
                o_pix.red   = widen5(i_src_pixel[15:11]);
                o_pix.green = widen6(i_src_pixel[10:5]);
                o_pix.blue  = widen5(i_src_pixel[4:0]);
                o_pix.alpha = CHAN_MAX;
            end
            FMT_RGBA4444: begin
                o_pix.red   = widen4(i_src_pixel[15:12]);
                o_pix.green = widen4(i_src_pixel[11:8]);
                o_pix.blue  = widen4(i_src_pixel[7:4]);
                o_pix.alpha = widen4(i_src_pixel[3:0]);
            end
            FMT_RGBA5551: begin
                o_pix.red   = widen5(i_src_pixel[15:11]);
                o_pix.green = widen5(i_src_pixel[10:6]);
                o_pix.blue  = widen5(i_src_pixel[5:1]);
                o_pix.alpha = widen1(i_src_pixel[0]);
            end
            default: begin
                o_fmt_ok = 1'b0;
            end
        endcase
    end

endmodule

// ===== sv/pfrgb_premul.sv =====
// Output formatting: RGBA8888 pass-through, alpha-premultiplied RGB888, or zero on a bad format
module pfrgb_premul (
    input  pfrgb_pkg::t_rgba i_pix,
    input  logic             i_fmt_ok,
    input  logic             i_with_alpha,
    output pfrgb_pkg::t_rgba o_pix
);
    import pfrgb_pkg::*;

    // floor(x/255) for any x up to 65279, which covers every 8x8 product
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        logic [16:0] s;
        t = {1'b0, x} + 17'd1;
        s = t + {8'd0, t[16:8]};
        return s[15:8];
    endfunction

    logic [15:0] w_red_a;
    logic [15:0] w_green_a;
    logic [15:0] w_blue_a;

    assign w_red_a   = i_pix.red   * i_pix.alpha;
    assign w_green_a = i_pix.green * i_pix.alpha;
    assign w_blue_a  = i_pix.blue  * i_pix.alpha;

    always_comb begin
        if (!i_fmt_ok) begin
            o_pix = '0;
        end else if (i_with_alpha) begin
            o_pix = i_pix;
        end else begin
            o_pix.red   = div255(w_red_a);
            o_pix.green = div255(w_green_a);
            o_pix.blue  = div255(w_blue_a);
            o_pix.alpha = 8'd0;
        end
    end

endmodule

// ===== sv/pixel_format_to_rgb_rgba.sv =====
// Top level of the pixel format converter to RGBA8888 / premultiplied RGB888
//
// Converts one source pixel per clock while the output is taken, with no
// state between pixels. The pixel lands in an input register, then format
// decode, channel widening, the 8x8 premultiply and the divide by 255 run in
// one pass into the output register. The input register refills whenever it
// is empty or the output register moves on, so the input stalls only when
// both registers are full and the output transaction is not taken. The
// source format and alpha mode registers are sampled as each pixel is
// converted, so change them only while the stream is empty.
module pixel_format_to_rgb_rgba (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic        i_cfg_index,
    input  logic [2:0]  i_cfg_data,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,    // [31:0] src_pixel
    input  logic        i_s_tlast,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,    // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
    output logic        o_m_tlast
);
    import pfrgb_pkg::*;

    t_src_fmt    r_src_format;
    logic        r_with_alpha;

    logic        r_v1;
    logic [31:0] r_px1;
    logic        r_last1;

    logic        r_v2;
    t_rgba       r_out;
    logic        r_last2;

    logic        w_en1;
    logic        w_en2;
    t_rgba       w_unpacked;
    logic        w_fmt_ok;
    t_rgba       n_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_format <= FMT_RGB888;
            r_with_alpha <= 1'b1;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_SRC_FORMAT:     r_src_format <= t_src_fmt'(i_cfg_data);
                CFG_DST_WITH_ALPHA: r_with_alpha <= i_cfg_data[0];
                default:            r_with_alpha <= r_with_alpha;
            endcase
        end
    end

    assign w_en2      = !r_v2 || i_m_tready;
    assign w_en1      = !r_v1 || w_en2;
    assign o_s_tready = w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (w_en1) begin
            r_v1 <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en1 && i_s_tvalid) begin
            r_px1   <= i_s_tdata;
            r_last1 <= i_s_tlast;
        end
    end

    pfrgb_unpack u_unpack (
        .i_src_pixel  (r_px1),
        .i_src_format (r_src_format),
        .o_pix        (w_unpacked),
        .o_fmt_ok     (w_fmt_ok)
    );

    pfrgb_premul u_premul (
        .i_pix        (w_unpacked),
        .i_fmt_ok     (w_fmt_ok),
        .i_with_alpha (r_with_alpha),
        .o_pix        (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (w_en2) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en2 && r_v1) begin
            r_out   <= n_out;
            r_last2 <= r_last1;
        end
    end

    assign o_m_tvalid = r_v2;
    assign o_m_tdata  = r_out;
    assign o_m_tlast  = r_last2;

endmodule

// ===== sv/pfrgb_checker.sv =====
// Port-level checker for the pixel format converter, bound to the top level
`include "pixel_format_to_rgb_rgba_macros.svh"

module pfrgb_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_tready,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] o_m_tdata,
    input logic        o_m_tlast
);

    `PFRGB_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid, "output transaction dropped while stalled")
    `PFRGB_ASSERT(a_out_stable, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> $stable(o_m_tdata) && $stable(o_m_tlast), "output payload changed while stalled")
    `PFRGB_ASSERT(a_no_bubble, i_clk, i_rst_n, (!o_m_tvalid || i_m_tready) |-> o_s_tready, "input stalled with free output register")
    `PFRGB_ASSERT_NR(a_reset_empty, i_clk, !i_rst_n |=> !o_m_tvalid, "output valid right after reset")

endmodule

bind pixel_format_to_rgb_rgba pfrgb_checker u_pfrgb_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
